>>> rtl/don_pkg.sv
// shared types and constants for the delayed oscillator network step unit
package don_pkg;

  // default sizes
  localparam int MAX_NODES_DEF = 64;
  localparam int HIST_DEPTH_DEF = 256;
  localparam int SINE_TABLE_SIZE_DEF = 1024;

  // stream and configuration port widths
  localparam int IN_TDATA_W = 80;
  localparam int IN_TUSER_W = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // item kinds carried in tuser
  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_INIT   = 2'd1,
    KIND_UPDATE = 2'd2
  } kind_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUPLING_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_SCALE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SCALE   = 3'd4;

  // register reset values
  localparam logic [6:0]         NODE_COUNT_RST    = 7'd64;
  localparam logic [15:0]        STEP_SIZE_RST     = 16'd410;
  localparam logic signed [15:0] COUPLING_GAIN_RST = 16'sd4096;
  localparam logic [15:0]        DELAY_SCALE_RST   = 16'd256;
  localparam logic [23:0]        NOISE_SCALE_RST   = 24'd1678;

  // fixed point constants
  localparam logic [29:0] RECIP_2PI_Q32 = 30'd683565276;
  localparam logic [18:0] D_Q24 = 19'd335544;
  localparam logic [15:0] INIT_V = 16'd4;
  localparam longint Q30 = 64'sd1 <<< 30;

  // odd sine polynomial in q30
  localparam longint A1 = 64'sd1686629713;
  localparam longint A3 = -64'sd693598669;
  localparam longint A5 = 64'sd85569306;
  localparam longint A7 = -64'sd5026996;
  localparam longint A9 = 64'sd172272;

endpackage

>>> rtl/delayed_oscillator_network_step_unit.sv
// top level of the delayed oscillator network step unit
//
// one input stream carries transactions of three kinds, selected by tuser:
// load writes one weight / tract length pair, init restarts the network and
// update advances the next node by one euler-maruyama step. only an update
// produces an output transaction (node, new v, new w; tlast marks the last
// active node of a time step). configuration writes go through cfg_we_i and
// are taken at any edge; they are only meaningful while the unit is idle.
// a load leaves the unit idle and ready for the next transaction. in an
// update the source walk issues one coupling-table read per cycle into an
// eight stage pipeline (delay, history read, phase, sine rom, accumulate),
// then a five step polynomial sequencer finishes the node. the history
// memory has one read and one write port, so the walk is bound by the
// single coupling-table read port. after reset and after every init a
// clearing sweep writes all HIST_DEPTH * MAX_NODES history entries, one a
// cycle, while s_axis_tready stays low. the result sits in an output
// register; a new transaction is taken while it waits, but an update that
// finishes while the register is still full holds until the receiver takes it
module delayed_oscillator_network_step_unit #(
  parameter int MAX_NODES = don_pkg::MAX_NODES_DEF,
  parameter int HIST_DEPTH = don_pkg::HIST_DEPTH_DEF,
  parameter int SINE_TABLE_SIZE = don_pkg::SINE_TABLE_SIZE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // row[5:0], col[11:6], weight[27:12], tract_len[43:28],
  // noise_v[59:44], noise_w[75:60], zero pad[79:76]
  input  logic [don_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // kind[1:0]
  input  logic [don_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // node[5:0], v_value[21:6], w_value[37:22], zero pad[39:38]
  output logic [don_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               cfg_we_i,
  input  logic [don_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [don_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import don_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int TW = $clog2(HIST_DEPTH);
  localparam int CAW = $clog2(MAX_NODES * MAX_NODES);
  localparam int HDEPTH = HIST_DEPTH * MAX_NODES;
  localparam int HAW = $clog2(HDEPTH);
  localparam int SAW = $clog2(SINE_TABLE_SIZE);
  localparam int IDXW = $clog2(SINE_TABLE_SIZE + 1);
  localparam int ACCW = 30 + NW;
  localparam int PW = ((ACCW + 4 > 36) ? ACCW + 4 : 36) + 2;
  // ceil(2^32 / HIST_DEPTH) for the delay modulo
  localparam longint RECIP_H = ((64'sd1 <<< 32) + HIST_DEPTH - 1) / HIST_DEPTH;

  localparam logic signed [PW:0] V_LO = (PW + 1)'(-2 * 16777216);
  localparam logic signed [PW:0] V_HI = (PW + 1)'(4 * 16777216);
  localparam logic signed [36:0] W_LO = 37'(-6 * 16777216);
  localparam logic signed [36:0] W_HI = 37'(6 * 16777216);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_CLEAR = 10'b00_0000_0010,
    ST_SELF  = 10'b00_0000_0100,
    ST_LOOP  = 10'b00_0000_1000,
    ST_DRAIN = 10'b00_0001_0000,
    ST_P1    = 10'b00_0010_0000,
    ST_P2    = 10'b00_0100_0000,
    ST_P3    = 10'b00_1000_0000,
    ST_P4    = 10'b01_0000_0000,
    ST_OUT   = 10'b10_0000_0000
  } state_e;

  typedef logic signed [13:0] sine_rom_t [SINE_TABLE_SIZE];

  // quarter-wave polynomial, rounded to q1.12
  function automatic logic signed [13:0] sine_entry(longint k);
    longint ph, q, z, z2, p, s, r;
    ph = (k <<< 32) / SINE_TABLE_SIZE;
    q = ph >>> 30;
    z = ph & 64'sh3FFF_FFFF;
    if (q[0]) z = Q30 - z;
    z2 = (z * z) / Q30;
    p = A9;
    p = A7 + (p * z2) / Q30;
    p = A5 + (p * z2) / Q30;
    p = A3 + (p * z2) / Q30;
    p = A1 + (p * z2) / Q30;
    s = (p * z) / Q30;
    if (s < 0) s = 0;
    if (s > Q30) s = Q30;
    r = (s + (64'sd1 <<< 17)) >>> 18;
    return 14'((q >= 2) ? -r : r);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < SINE_TABLE_SIZE; k++) begin
      rom[k] = sine_entry(longint'(k));
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // memories: coupling {tract_len, weight}, history {w, v}
  logic [31:0] coup_mem [MAX_NODES * MAX_NODES];
  logic [31:0] hist_mem [HDEPTH];

  // control state
  state_e          state_q, state_d;
  logic [HAW-1:0]  clr_q, clr_d;
  logic            clr_init_q, clr_init_d;
  logic [TW-1:0]   t_q, t_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic [NW-1:0]   node_q, node_d;
  logic [NCW-1:0]  n_q, n_d;
  logic [NW-1:0]   j_q, j_d;
  logic            vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vh_q;
  logic            m_valid_q, m_valid_d;

  // configuration registers
  logic [6:0]         node_count_q;
  logic [15:0]        step_size_q;
  logic signed [15:0] gain_q;
  logic [15:0]        dscale_q;
  logic [23:0]        nscale_q;

  // input field unpacking
  logic [5:0]         in_row, in_col;
  logic [15:0]        in_weight, in_len;
  logic signed [15:0] in_nv, in_nw;
  logic               in_acc;

  assign in_row    = s_axis_tdata[5:0];
  assign in_col    = s_axis_tdata[11:6];
  assign in_weight = s_axis_tdata[27:12];
  assign in_len    = s_axis_tdata[43:28];
  assign in_nv     = s_axis_tdata[59:44];
  assign in_nw     = s_axis_tdata[75:60];
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // active node count and next node
  logic [NCW-1:0] n_act;
  logic [NW-1:0]  i_sel;
  logic [HAW-1:0] self_addr;

  always_comb begin
    if (node_count_q == 7'd0) begin
      n_act = NCW'(1);
    end else if (32'(node_count_q) > MAX_NODES) begin
      n_act = NCW'(MAX_NODES);
    end else begin
      n_act = NCW'(node_count_q);
    end
    i_sel = (NCW'(cnt_q) >= n_act) ? '0 : cnt_q;
    self_addr = HAW'(t_q) * HAW'(MAX_NODES) + HAW'(i_sel);
  end

  // payload registers of the source walk and the node update
  logic [31:0]              coup_rd_q;
  logic [31:0]              hist_rd_q;
  logic [NW-1:0]            jb_q, jc_q, jd_q, je_q;
  logic signed [15:0]       wt_c_q, wt_d_q, wt_e_q, wt_f_q, wt_g_q, wt_h_q;
  logic [15:0]              dd_c_q, dd_d_q;
  logic [15:0]              q_d_q;
  logic [TW-1:0]            r_e_q;
  logic [43:0]              p_g_q;
  logic signed [13:0]       sine_q;
  logic signed [ACCW-1:0]   acc_q;
  logic signed [15:0]       vi_q, wi_q, nv_q_in, nw_q_in;
  logic signed [ACCW+15:0]  cprod_q;
  logic signed [31:0]       vv_q;
  logic [39:0]              ds_q;
  logic signed [ACCW+3:0]   c24_q;
  logic signed [47:0]       v3p_q;
  logic signed [56:0]       nvp_q, nwp_q;
  logic signed [PW-1:0]     poly_q;
  logic signed [35:0]       dwin_q;
  logic signed [32:0]       nv_q, nw_q;
  logic signed [PW+19:0]    dvp_q;
  logic signed [55:0]       dwp_q;

  // stage b: delay in slots
  logic [31:0] b_prod;
  logic [15:0] b_dd;
  // stage c: reciprocal product for the modulo
  logic [46:0] c_prod;
  // stage d: remainder
  logic [16:0] d_qh, d_r;
  // stage e: source slot and history address
  logic [TW:0]    e_slot;
  logic [HAW-1:0] e_addr, hist_raddr;
  // stage f: phase product
  logic signed [16:0] f_diff;
  logic signed [47:0] f_prod;
  // stage g: table index
  logic [43:0]        g_phr;
  logic [31+IDXW:0]   g_ix;
  logic [IDXW-1:0]    g_idx;
  logic [SAW-1:0]     g_addr;
  // stage h: weighted sine
  logic signed [29:0] h_prod;

  always_comb begin
    b_prod = coup_rd_q[31:16] * dscale_q;
    b_dd = b_prod[31:16];
    c_prod = 47'(dd_c_q) * 47'(RECIP_H);
    d_qh = 17'(q_d_q) * 17'(HIST_DEPTH);
    d_r = {1'b0, dd_d_q} - d_qh;
    if (d_r >= 17'(HIST_DEPTH)) d_r = d_r - 17'(HIST_DEPTH);
    e_slot = (TW + 1)'(t_q) + (TW + 1)'(HIST_DEPTH) - (TW + 1)'(r_e_q);
    if (e_slot >= (TW + 1)'(HIST_DEPTH)) e_slot = e_slot - (TW + 1)'(HIST_DEPTH);
    e_addr = HAW'(e_slot) * HAW'(MAX_NODES) + HAW'(je_q);
    hist_raddr = (state_q == ST_IDLE) ? self_addr : e_addr;
    f_diff = 17'(signed'(hist_rd_q[15:0])) - 17'(vi_q);
    f_prod = f_diff * $signed({1'b0, RECIP_2PI_Q32});
    g_phr = p_g_q + 44'd2048;
    g_ix = (32 + IDXW)'(g_phr[43:12]) * (32 + IDXW)'(SINE_TABLE_SIZE)
         + (32 + IDXW)'(64'h8000_0000);
    g_idx = g_ix[31+IDXW:32];
    g_addr = (32'(g_idx) >= SINE_TABLE_SIZE) ? '0 : SAW'(g_idx);
    h_prod = wt_h_q * sine_q;
  end

  // final arithmetic of the node update
  logic signed [ACCW+15:0] p2_ct;
  logic signed [47:0]      p3_vt;
  logic signed [35:0]      p3_v3;
  logic signed [56:0]      p3_nvt, p3_nwt;
  logic signed [PW+19:0]   o_dvt;
  logic signed [55:0]      o_dwt;
  logic signed [PW-1:0]    o_dv;
  logic signed [31:0]      o_dw;
  logic signed [PW:0]      o_vs, o_vc, o_vr;
  logic signed [36:0]      o_ws, o_wc, o_wr;
  logic signed [15:0]      o_vn, o_wn;

  always_comb begin
    p2_ct = cprod_q + (cprod_q[ACCW+15] ? (ACCW + 16)'(4095) : '0);
    p3_vt = v3p_q + (v3p_q[47] ? 48'(4095) : '0);
    p3_v3 = 36'(p3_vt >>> 12);
    p3_nvt = nvp_q + (nvp_q[56] ? 57'(24'hFF_FFFF) : '0);
    p3_nwt = nwp_q + (nwp_q[56] ? 57'(24'hFF_FFFF) : '0);
    o_dvt = dvp_q + (dvp_q[PW+19] ? (PW + 20)'(24'hFF_FFFF) : '0);
    o_dwt = dwp_q + (dwp_q[55] ? 56'(24'hFF_FFFF) : '0);
    o_dv = PW'(o_dvt >>> 24);
    o_dw = 32'(o_dwt >>> 24);
    o_vs = ((PW + 1)'(vi_q) <<< 12) + (PW + 1)'(nv_q) + (PW + 1)'(o_dv);
    o_ws = (37'(wi_q) <<< 12) + 37'(nw_q) + 37'(o_dw);
    o_vc = o_vs;
    if (o_vs < V_LO) o_vc = V_LO;
    if (o_vs > V_HI) o_vc = V_HI;
    o_wc = o_ws;
    if (o_ws < W_LO) o_wc = W_LO;
    if (o_ws > W_HI) o_wc = W_HI;
    o_vr = o_vc + 2048;
    o_wr = o_wc + 2048;
    o_vn = 16'(o_vr >>> 12);
    o_wn = 16'(o_wr >>> 12);
  end

  // output register can take a result
  logic out_free;
  logic last_node;
  logic [TW-1:0] t_nxt;

  assign out_free = !m_valid_q || m_axis_tready;
  assign last_node = (NCW'(node_q) + NCW'(1)) == n_q;
  assign t_nxt = (32'(t_q) == HIST_DEPTH - 1) ? '0 : t_q + TW'(1);

  // history write port: clearing sweep or node result
  logic           hist_we;
  logic [HAW-1:0] hist_waddr;
  logic [31:0]    hist_wdata;

  always_comb begin
    hist_we = 1'b0;
    hist_waddr = clr_q;
    hist_wdata = '0;
    if (state_q == ST_CLEAR) begin
      hist_we = 1'b1;
      if (clr_init_q && (32'(clr_q) < MAX_NODES)) hist_wdata = {16'd0, INIT_V};
    end else if (state_q == ST_OUT && out_free) begin
      hist_we = 1'b1;
      hist_waddr = HAW'(t_nxt) * HAW'(MAX_NODES) + HAW'(node_q);
      hist_wdata = {o_wn, o_vn};
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    clr_init_d = clr_init_q;
    t_d = t_q;
    cnt_d = cnt_q;
    node_d = node_q;
    n_d = n_q;
    j_d = j_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == KIND_INIT) begin
            state_d = ST_CLEAR;
            clr_d = '0;
            clr_init_d = 1'b1;
            t_d = '0;
            cnt_d = '0;
          end else if (s_axis_tuser == KIND_UPDATE) begin
            state_d = ST_SELF;
            node_d = i_sel;
            n_d = n_act;
          end
        end
      end
      ST_CLEAR: begin
        clr_d = clr_q + HAW'(1);
        if (32'(clr_q) == HDEPTH - 1) state_d = ST_IDLE;
      end
      ST_SELF: begin
        j_d = '0;
        state_d = ST_LOOP;
      end
      ST_LOOP: begin
        j_d = j_q + NW'(1);
        if ((NCW'(j_q) + NCW'(1)) == n_q) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!(vb_q || vc_q || vd_q || ve_q || vf_q || vg_q || vh_q)) state_d = ST_P1;
      end
      ST_P1: state_d = ST_P2;
      ST_P2: state_d = ST_P3;
      ST_P3: state_d = ST_P4;
      ST_P4: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          state_d = ST_IDLE;
          if (last_node) begin
            t_d = t_nxt;
            cnt_d = '0;
          end else begin
            cnt_d = node_q + NW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      clr_init_q <= 1'b0;
      t_q <= '0;
      cnt_q <= '0;
      node_q <= '0;
      n_q <= '0;
      j_q <= '0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      vh_q <= 1'b0;
      m_valid_q <= 1'b0;
      node_count_q <= NODE_COUNT_RST;
      step_size_q <= STEP_SIZE_RST;
      gain_q <= COUPLING_GAIN_RST;
      dscale_q <= DELAY_SCALE_RST;
      nscale_q <= NOISE_SCALE_RST;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      clr_init_q <= clr_init_d;
      t_q <= t_d;
      cnt_q <= cnt_d;
      node_q <= node_d;
      n_q <= n_d;
      j_q <= j_d;
      vb_q <= (state_q == ST_LOOP);
      vc_q <= vb_q && (coup_rd_q[15:0] != 16'd0);
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
      vg_q <= vf_q;
      vh_q <= vg_q;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_NODE_COUNT:    node_count_q <= cfg_data_i[6:0];
          CFG_STEP_SIZE:     step_size_q <= cfg_data_i[15:0];
          CFG_COUPLING_GAIN: gain_q <= cfg_data_i[15:0];
          CFG_DELAY_SCALE:   dscale_q <= cfg_data_i[15:0];
          CFG_NOISE_SCALE:   nscale_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // coupling table
  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser == KIND_LOAD && 32'(in_row) < MAX_NODES
        && 32'(in_col) < MAX_NODES) begin
      coup_mem[CAW'(in_row) * CAW'(MAX_NODES) + CAW'(in_col)] <= {in_len, in_weight};
    end
  end

  always_ff @(posedge clk_i) begin
    coup_rd_q <= coup_mem[CAW'(node_q) * CAW'(MAX_NODES) + CAW'(j_q)];
  end

  // history
  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
  end

  always_ff @(posedge clk_i) begin
    hist_rd_q <= hist_mem[hist_raddr];
  end

  // walk pipeline and node arithmetic
  always_ff @(posedge clk_i) begin
    jb_q <= j_q;
    jc_q <= jb_q;
    jd_q <= jc_q;
    je_q <= jd_q;
    wt_c_q <= coup_rd_q[15:0];
    wt_d_q <= wt_c_q;
    wt_e_q <= wt_d_q;
    wt_f_q <= wt_e_q;
    wt_g_q <= wt_f_q;
    wt_h_q <= wt_g_q;
    dd_c_q <= b_dd;
    dd_d_q <= dd_c_q;
    q_d_q <= 16'(c_prod >> 32);
    r_e_q <= TW'(d_r);
    p_g_q <= f_prod[43:0];
    sine_q <= SINE_ROM[g_addr];
    if (in_acc) begin
      nv_q_in <= in_nv;
      nw_q_in <= in_nw;
    end
    if (state_q == ST_SELF) begin
      vi_q <= hist_rd_q[15:0];
      wi_q <= hist_rd_q[31:16];
      acc_q <= '0;
    end else if (vh_q) begin
      acc_q <= acc_q + ACCW'(h_prod);
    end
    if (state_q == ST_P1) begin
      cprod_q <= gain_q * acc_q;
      vv_q <= vi_q * vi_q;
      ds_q <= step_size_q * nscale_q;
    end
    if (state_q == ST_P2) begin
      c24_q <= (ACCW + 4)'(p2_ct >>> 12);
      v3p_q <= vv_q * vi_q;
      nvp_q <= $signed({1'b0, ds_q}) * nv_q_in;
      nwp_q <= $signed({1'b0, ds_q}) * nw_q_in;
    end
    if (state_q == ST_P3) begin
      poly_q <= (PW'(wi_q) <<< 12) - PW'(p3_v3) + PW'(vv_q) * PW'(3) + PW'(c24_q);
      dwin_q <= 36'(-2 * 16777216) - 36'(vi_q) * 36'(40960) - (36'(wi_q) <<< 12);
      nv_q <= 33'(p3_nvt >>> 24);
      nw_q <= 33'(p3_nwt >>> 24);
    end
    if (state_q == ST_P4) begin
      dvp_q <= poly_q * $signed({1'b0, D_Q24});
      dwp_q <= dwin_q * $signed({1'b0, D_Q24});
    end
  end

  // output register
  logic [OUT_TDATA_W-1:0] m_data_q;
  logic                   m_last_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      m_data_q <= {2'b00, o_wn, o_vn, 6'(node_q)};
      m_last_q <= last_node;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata = m_data_q;
  assign m_axis_tlast = m_last_q;

endmodule

>>> tb/sv/don_step_checker.sv
// checker for the oscillator network step unit: tracks state, predicts node updates, compares
module don_step_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [don_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic [don_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [don_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic [don_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [don_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output int                                errors_o,
  output int                                pending_o,
  output int                                results_o
);
  import don_pkg::*;

  localparam int NODES = 64;
  localparam int DEPTH = 256;
  localparam int SINE_N = 1024;
  localparam longint Q24 = 64'sd1 <<< 24;
  localparam longint Q12 = 64'sd4096;

  typedef struct {
    logic [5:0]  node;
    logic [15:0] v_value;
    logic [15:0] w_value;
    logic        step_done;
  } node_result_t;

  node_result_t  expected_steps[$];

  logic [6:0]    nodes_reg;
  logic [15:0]   dt_reg;
  logic signed [15:0] gain_reg;
  logic [15:0]   dscale_reg;
  logic [23:0]   sigma_reg;

  shortint       weights[NODES*NODES];
  logic [15:0]   lengths[NODES*NODES];
  shortint       v_hist[DEPTH*NODES];
  shortint       w_hist[DEPTH*NODES];
  int            slot_now;
  int            next_node;
  int            sine_lut[SINE_N];
  int            errors;
  int            results;

  function automatic int sine_point(int k);
    longint ph, z, z2, p, s, r;
    int q;
    ph = (longint'(k) <<< 32) / SINE_N;
    q = int'(ph >>> 30);
    z = ph & 64'h3FFF_FFFF;
    if (q % 2 == 1) z = Q30 - z;
    z2 = (z * z) / Q30;
    p = A9;
    p = A7 + (p * z2) / Q30;
    p = A5 + (p * z2) / Q30;
    p = A3 + (p * z2) / Q30;
    p = A1 + (p * z2) / Q30;
    s = (p * z) / Q30;
    if (s < 0) s = 0;
    if (s > Q30) s = Q30;
    r = (s + (64'sd1 <<< 17)) / (64'sd1 <<< 18);
    return (q >= 2) ? -int'(r) : int'(r);
  endfunction

  // phase difference in q4.12 to q1.12 sine through the turn scaling
  function automatic int sine_of_diff(int diff);
    bit [63:0] prod, idx;
    bit [31:0] turn;
    prod = 64'(longint'(diff)) * 64'd683565276;
    turn = 32'((prod + 64'd2048) >> 12);
    idx = ({32'b0, turn} * 64'd1024 + 64'h8000_0000) >> 32;
    if (idx >= SINE_N) idx = 0;
    return sine_lut[idx];
  endfunction

  function automatic shortint clamp_q12(longint x24, longint lo, longint hi);
    if (x24 < lo * Q24) x24 = lo * Q24;
    if (x24 > hi * Q24) x24 = hi * Q24;
    return shortint'((x24 + 8 * Q24 + 2048) / Q12 - 8 * Q12);
  endfunction

  task automatic advance_node(logic [15:0] nz_v, logic [15:0] nz_w);
    int n, i, t, nxt, j, dly, slot;
    longint v, w, acc, c24, v3, poly, dv, dw, ds, nv, nw;
    shortint vn, wn;
    node_result_t res;
    n = (nodes_reg < 1) ? 1 : ((nodes_reg > NODES) ? NODES : int'(nodes_reg));
    // counter restarts when node_count shrank below it
    if (next_node >= n) next_node = 0;
    i = next_node;
    t = slot_now;
    v = v_hist[t*NODES + i];
    w = w_hist[t*NODES + i];
    acc = 0;
    for (j = 0; j < n; j++) begin
      if (weights[i*NODES + j] != 0) begin
        dly = int'((longint'(lengths[i*NODES + j]) * longint'(dscale_reg)) >>> 16);
        slot = (t + DEPTH - (dly % DEPTH)) % DEPTH;
        acc += longint'(weights[i*NODES + j]) *
               sine_of_diff(int'(v_hist[slot*NODES + j]) - int'(v));
      end
    end
    c24 = (longint'(gain_reg) * acc) / Q12;
    v3 = (v * v * v) / Q12;
    poly = w * Q12 - v3 + 3 * v * v + c24;
    dv = (poly * longint'(D_Q24)) / Q24;
    dw = ((-2 * Q24 - 10 * v * Q12 - w * Q12) * longint'(D_Q24)) / Q24;
    ds = longint'(dt_reg) * longint'(sigma_reg);
    nv = (ds * longint'($signed(nz_v))) / Q24;
    nw = (ds * longint'($signed(nz_w))) / Q24;
    vn = clamp_q12(v * Q12 + nv + dv, -2, 4);
    wn = clamp_q12(w * Q12 + nw + dw, -6, 6);
    nxt = (t + 1) % DEPTH;
    v_hist[nxt*NODES + i] = vn;
    w_hist[nxt*NODES + i] = wn;
    res.node = 6'(i);
    res.v_value = vn;
    res.w_value = wn;
    res.step_done = (i + 1 == n);
    expected_steps.push_back(res);
    if (i + 1 == n) begin
      slot_now = nxt;
      next_node = 0;
    end else begin
      next_node = i + 1;
    end
  endtask

  task automatic check_result();
    node_result_t exp_r;
    if (expected_steps.size() == 0) begin
      $error("result transaction with no expectation: tdata=%h", m_axis_tdata);
      errors++;
      return;
    end
    exp_r = expected_steps.pop_front();
    if (m_axis_tdata[5:0] != exp_r.node) begin
      $error("node: expected %0d actual %0d", exp_r.node, m_axis_tdata[5:0]);
      errors++;
    end
    if (m_axis_tdata[21:6] != exp_r.v_value) begin
      $error("v_value: expected %0d actual %0d", $signed(exp_r.v_value),
             $signed(m_axis_tdata[21:6]));
      errors++;
    end
    if (m_axis_tdata[37:22] != exp_r.w_value) begin
      $error("w_value: expected %0d actual %0d", $signed(exp_r.w_value),
             $signed(m_axis_tdata[37:22]));
      errors++;
    end
    if (m_axis_tlast != exp_r.step_done) begin
      $error("step_done: expected %0d actual %0d", exp_r.step_done, m_axis_tlast);
      errors++;
    end
    results++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int k;
    if (!rst_ni) begin
      nodes_reg = NODE_COUNT_RST;
      dt_reg = STEP_SIZE_RST;
      gain_reg = COUPLING_GAIN_RST;
      dscale_reg = DELAY_SCALE_RST;
      sigma_reg = NOISE_SCALE_RST;
      for (k = 0; k < DEPTH*NODES; k++) begin
        v_hist[k] = 0;
        w_hist[k] = 0;
      end
      for (k = 0; k < SINE_N; k++) sine_lut[k] = sine_point(k);
      slot_now = 0;
      next_node = 0;
      errors = 0;
      results = 0;
      expected_steps.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NODE_COUNT:    nodes_reg = cfg_data_i[6:0];
          CFG_STEP_SIZE:     dt_reg = cfg_data_i[15:0];
          CFG_COUPLING_GAIN: gain_reg = cfg_data_i[15:0];
          CFG_DELAY_SCALE:   dscale_reg = cfg_data_i[15:0];
          CFG_NOISE_SCALE:   sigma_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          KIND_LOAD: begin
            weights[s_axis_tdata[5:0]*NODES + s_axis_tdata[11:6]] = s_axis_tdata[27:12];
            lengths[s_axis_tdata[5:0]*NODES + s_axis_tdata[11:6]] = s_axis_tdata[43:28];
          end
          KIND_INIT: begin
            for (k = 0; k < DEPTH*NODES; k++) begin
              v_hist[k] = 0;
              w_hist[k] = 0;
            end
            for (k = 0; k < NODES; k++) v_hist[k] = shortint'(INIT_V);
            slot_now = 0;
            next_node = 0;
          end
          KIND_UPDATE: advance_node(s_axis_tdata[59:44], s_axis_tdata[75:60]);
          default: ;
        endcase
      end
    end
    errors_o <= errors;
    pending_o <= expected_steps.size();
    results_o <= results;
  end

endmodule

>>> tb/sv/delayed_oscillator_network_step_unit_tb.sv
// testbench top: stimulus, handshake idling and verdict for the step unit
module delayed_oscillator_network_step_unit_tb;
  import don_pkg::*;

  // kind 3 is not a member of the package enum and must be ignored
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // row[5:0], col[11:6], weight[27:12], tract_len[43:28],
  // noise_v[59:44], noise_w[75:60], zero pad[79:76]
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  // kind[1:0]
  logic [IN_TUSER_W-1:0]   s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // node[5:0], v_value[21:6], w_value[37:22], zero pad[39:38]
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    m_axis_tlast;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;

  int errors, pending, results;
  bit gaps_on = 1'b1;          // random idling on both sides when set
  bit long_hold_done = 1'b0;
  bit loaded[64][64];          // coupling entries written so far
  int n_loads, n_updates, n_inits, n_phases;

  delayed_oscillator_network_step_unit i_dut (.*);

  don_step_checker i_checker (
    .errors_o(errors), .pending_o(pending), .results_o(results), .*
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // overall watchdog, far above the slowest legal run
  initial begin
    #100000000;
    $display("delayed_oscillator_network_step_unit verification failed");
    $finish;
  end

  // receiver: random stall per result transaction, plus one long hold-off
  // so the output register fills and the unit back-pressures the input
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = gaps_on ? $urandom_range(15) : 0;
      if (!long_hold_done && results >= 200) begin
        long_hold_done = 1'b1;
        gap = 600;
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // mostly random, often an edge value of the given width
  function automatic logic [31:0] edgy(int width);
    logic [31:0] all = (32'd1 << width) - 1;
    case ($urandom_range(7))
      0: return 0;
      1: return all;
      2: return 32'd1 << (width - 1);
      3: return all >> 1;
      default: return $urandom() & all;
    endcase
  endfunction

  // one input transaction; called at a rising edge, returns at its accept edge
  task automatic send(logic [1:0] kind, logic [5:0] row, logic [5:0] col,
                      logic [15:0] wt, logic [15:0] len, logic [15:0] nv,
                      logic [15:0] nw);
    int gap;
    gap = gaps_on ? $urandom_range(15) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {4'b0, nw, nv, len, wt, col, row};
    do @(posedge clk_i); while (!s_axis_tready);
    case (kind)
      KIND_LOAD: begin
        loaded[row][col] = 1'b1;
        n_loads++;
      end
      KIND_INIT: n_inits++;
      KIND_UPDATE: n_updates++;
      default: ;
    endcase
  endtask

  task automatic send_load(int row, int col, logic [15:0] wt, logic [15:0] len);
    send(KIND_LOAD, 6'(row), 6'(col), wt, len, 16'h0, 16'h0);
  endtask

  task automatic send_update(logic [15:0] nv, logic [15:0] nw);
    send(KIND_UPDATE, 6'($urandom()), 6'($urandom()), 16'($urandom()),
         16'($urandom()), nv, nw);
  endtask

  // every coupling entry an update may read must be written first
  task automatic fill_tables(int rows, int cols);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        if (!loaded[r][c])
          send_load(r, c, ($urandom_range(3) == 0) ? 16'h0 : 16'(edgy(16)),
                    16'(edgy(16)));
  endtask

  // wait until every result is back and the unit takes input again
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || !s_axis_tready);
  endtask

  task automatic set_regs(logic [6:0] n, logic [15:0] dt, logic [15:0] g,
                          logic [15:0] ds, logic [23:0] sigma);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_NODE_COUNT;    cfg_data_i <= 24'(n);     @(posedge clk_i);
    cfg_idx_i <= CFG_STEP_SIZE;     cfg_data_i <= 24'(dt);    @(posedge clk_i);
    cfg_idx_i <= CFG_COUPLING_GAIN; cfg_data_i <= 24'(g);     @(posedge clk_i);
    cfg_idx_i <= CFG_DELAY_SCALE;   cfg_data_i <= 24'(ds);    @(posedge clk_i);
    cfg_idx_i <= CFG_NOISE_SCALE;   cfg_data_i <= sigma;      @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_phases++;
  endtask

  // random transactions: mostly updates, some reloads, rare inits and kind 3
  task automatic random_items(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(199);
      if (r == 0)
        send(KIND_INIT, 6'($urandom()), 6'($urandom()), 16'($urandom()),
             16'($urandom()), 16'($urandom()), 16'($urandom()));
      else if (r < 12)
        send(KIND_UNUSED, 6'($urandom()), 6'($urandom()), 16'($urandom()),
             16'($urandom()), 16'($urandom()), 16'($urandom()));
      else if (r < 50)
        send_load($urandom_range(63), $urandom_range(63),
                  ($urandom_range(5) == 0) ? 16'h0 : 16'(edgy(16)), 16'(edgy(16)));
      else
        send_update(16'(edgy(16)), 16'(edgy(16)));
    end
  endtask

  initial begin
    int n, m;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    drain();

    // directed: two nodes, extreme weights and lengths, update before init
    set_regs(7'd2, 16'hFFFF, 16'h7FFF, 16'hFFFF, 24'hFFFFFF);
    send_load(0, 0, 16'h7FFF, 16'h0000);
    send_load(0, 1, 16'h8000, 16'hFFFF);
    send_load(1, 0, 16'h0000, 16'h1234);
    send_load(1, 1, 16'hFFFF, 16'h0100);
    send_update(16'h7FFF, 16'h8000);
    send_update(16'h8000, 16'h7FFF);
    send(KIND_UNUSED, 6'h3F, 6'h3F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(KIND_INIT, 6'h0, 6'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    for (int k = 0; k < 6; k++) send_update(16'(edgy(16)), 16'(edgy(16)));
    send_update(16'h0, 16'h0);
    drain();
    // node_count zero acts as one, counter restarts after shrinking
    set_regs(7'd0, 16'h0, 16'h8000, 16'h0, 24'h0);
    for (int k = 0; k < 4; k++) send_update(16'h7FFF, 16'h7FFF);
    drain();
    set_regs(7'd1, 16'd410, 16'h8000, 16'd256, 24'd1678);
    send_update(16'h8000, 16'h8000);
    drain();

    // random phases across register settings
    for (int p = 0; p < 14; p++) begin
      gaps_on = (p % 4 != 3);
      case ($urandom_range(5))
        0: n = 0;
        1: n = 16;
        default: n = $urandom_range(1, 8);
      endcase
      set_regs(7'(n), 16'(edgy(16)), 16'(edgy(16)), 16'(edgy(16)), 24'(edgy(24)));
      m = (n == 0) ? 1 : n;
      fill_tables(m, m);
      random_items(70);
      drain();
    end

    // full network on its first rows: saturating node_count, then the maximum
    gaps_on = 1'b0;
    fill_tables(8, 64);
    gaps_on = 1'b1;
    drain();
    set_regs(7'd127, 16'(edgy(16)), 16'(edgy(16)), 16'(edgy(16)), 24'(edgy(24)));
    send(KIND_INIT, 6'h0, 6'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    for (int k = 0; k < 4; k++) send_update(16'(edgy(16)), 16'(edgy(16)));
    drain();
    set_regs(7'd64, 16'd410, 16'd4096, 16'd256, 24'd1678);
    for (int k = 0; k < 4; k++) send_update(16'(edgy(16)), 16'(edgy(16)));
    drain();

    $display("run covered %0d register phases, %0d loads, %0d updates, %0d inits",
             n_phases, n_loads, n_updates, n_inits);
    $display("%0d result transactions checked, long output hold-off %0s",
             results, long_hold_done ? "applied" : "not reached");
    if (errors == 0) begin
      $display("delayed_oscillator_network_step_unit verification clean");
    end else begin
      $display("delayed_oscillator_network_step_unit verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/don_pkg.sv
rtl/delayed_oscillator_network_step_unit.sv
tb/sv/don_step_checker.sv
tb/sv/delayed_oscillator_network_step_unit_tb.sv
